### hw/rtl/tsl_pkg.sv
// ----------------------------------------------------------------------------
// Thermistor smoothing and linearisation - shared definitions
// Widths, filter and table constants and the count-to-temperature table.
// ----------------------------------------------------------------------------
`default_nettype none

package tsl_pkg;

    // sample and filter sizes
    localparam int ADC_BITS      = 12;
    localparam int FILTER_SHIFT  = 3;
    localparam int SUM_W         = ADC_BITS + FILTER_SHIFT;

    // lookup table geometry
    localparam int TABLE_ENTRIES = 12;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int STEP_DECI     = 50;

    // temperature and limit widths
    localparam int TEMP_W        = 10;
    localparam int LIMIT_W       = 10;
    localparam int LIMIT_RESET   = 400;
    localparam int TEMP_MAX      = (TABLE_ENTRIES - 1) * STEP_DECI;

    // interpolation divider: quotient is always below STEP_DECI
    localparam int QUOT_W        = $clog2(STEP_DECI);
    localparam int NUM_W         = ADC_BITS + QUOT_W;
    localparam int CNT_W         = $clog2(QUOT_W);

    // descending ADC counts, one entry every 5.0 degC from 0.0 degC
    function automatic logic [ADC_BITS-1:0] count_at(input logic [IDX_W-1:0] idx);
        logic [ADC_BITS-1:0] val;
        unique case (idx)
            IDX_W'(0):  val = ADC_BITS'(3156);
            IDX_W'(1):  val = ADC_BITS'(2955);
            IDX_W'(2):  val = ADC_BITS'(2738);
            IDX_W'(3):  val = ADC_BITS'(2510);
            IDX_W'(4):  val = ADC_BITS'(2278);
            IDX_W'(5):  val = ADC_BITS'(2048);
            IDX_W'(6):  val = ADC_BITS'(1825);
            IDX_W'(7):  val = ADC_BITS'(1614);
            IDX_W'(8):  val = ADC_BITS'(1419);
            IDX_W'(9):  val = ADC_BITS'(1241);
            IDX_W'(10): val = ADC_BITS'(1081);
            IDX_W'(11): val = ADC_BITS'(940);
            default:    val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/thermistor_smooth_and_linearize_top.sv
// ----------------------------------------------------------------------------
// Thermistor smoothing and linearisation - top level
// Moving-average filter on raw counts, table search and interpolation
// through a table compare and a restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_raw_count
//  m_        out        m_valid / m_ready    m_temperature_deci, m_filtered_count,
//                                            m_too_hot
//  hot_limit in         hot_limit_wr_en      hot_limit_wr_data
//
// An item passes these steps from accept to result: the filter update at the
// accept edge, one table compare a cycle over up to 12 entries, then the
// restoring divider steps for an interpolated count, and a final step to load the
// result. s_ready returns once the result is loaded, so the block takes no new
// item before then.
// Reset (aresetn low, synchronous) clears the filter, the limit to 400 and the
// sequencer. A new item is taken while a finished result still waits; a stalled
// result holds the sequencer in its last step until m_ready.
`default_nettype none

module thermistor_smooth_and_linearize_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input items
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [tsl_pkg::ADC_BITS-1:0] s_raw_count,
    // result items
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [tsl_pkg::TEMP_W-1:0]        m_temperature_deci,
    output logic [tsl_pkg::ADC_BITS-1:0]      m_filtered_count,
    output logic                              m_too_hot,
    // limit register
    input  wire logic                         hot_limit_wr_en,
    input  wire logic [tsl_pkg::LIMIT_W-1:0]  hot_limit_wr_data
);

    import tsl_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DIVIDE = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    logic [1:0]          state_reg,   state_next;
    logic [SUM_W-1:0]    sum_reg,     sum_next;
    logic                seeded_reg,  seeded_next;
    logic [LIMIT_W-1:0]  limit_reg,   limit_next;
    logic [ADC_BITS-1:0] filt_reg,    filt_next;
    logic [IDX_W-1:0]    idx_reg,     idx_next;
    logic [ADC_BITS-1:0] div_reg,     div_next;
    logic [ADC_BITS-1:0] rem_reg,     rem_next;
    logic [QUOT_W-1:0]   quot_reg,    quot_next;
    logic [CNT_W-1:0]    cnt_reg,     cnt_next;
    logic [TEMP_W-1:0]   temp_reg,    temp_next;
    logic                m_valid_reg, m_valid_next;
    logic [TEMP_W-1:0]   m_temp_reg,  m_temp_next;
    logic [ADC_BITS-1:0] m_filt_reg,  m_filt_next;
    logic                m_hot_reg,   m_hot_next;

    // shared datapath signals
    logic [SUM_W-1:0]    sum_upd;
    logic [ADC_BITS-1:0] tab_val;
    logic [ADC_BITS-1:0] tab_prev;
    logic [ADC_BITS-1:0] span;
    logic [NUM_W-1:0]    num;
    logic [ADC_BITS:0]   trial;
    logic                trial_ge;
    logic [ADC_BITS:0]   trial_diff;
    logic [QUOT_W-1:0]   quot_upd;
    logic                s_fire;

    assign s_ready            = (state_reg == ST_IDLE);
    assign s_fire             = s_valid && s_ready;
    assign m_valid            = m_valid_reg;
    assign m_temperature_deci = m_temp_reg;
    assign m_filtered_count   = m_filt_reg;
    assign m_too_hot          = m_hot_reg;

    // filter update and table access
    always_comb begin
        if (seeded_reg) begin
            sum_upd = sum_reg - (sum_reg >> FILTER_SHIFT) + SUM_W'(s_raw_count);
        end else begin
            sum_upd = SUM_W'(s_raw_count) << FILTER_SHIFT;
        end
        tab_val  = count_at(idx_reg);
        tab_prev = count_at(idx_reg - IDX_W'(1));
        span     = tab_prev - filt_reg;
        num      = NUM_W'(span) * NUM_W'(STEP_DECI);
    end

    // one restoring divider step
    always_comb begin
        trial      = {rem_reg, quot_reg[QUOT_W-1]};
        trial_ge   = (trial >= {1'b0, div_reg});
        trial_diff = trial - {1'b0, div_reg};
        quot_upd   = {quot_reg[QUOT_W-2:0], trial_ge};
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        seeded_next  = seeded_reg;
        limit_next   = limit_reg;
        filt_next    = filt_reg;
        idx_next     = idx_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        cnt_next     = cnt_reg;
        temp_next    = temp_reg;
        m_valid_next = m_valid_reg;
        m_temp_next  = m_temp_reg;
        m_filt_next  = m_filt_reg;
        m_hot_next   = m_hot_reg;

        if (hot_limit_wr_en) begin
            limit_next = hot_limit_wr_data;
        end

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    sum_next    = sum_upd;
                    seeded_next = 1'b1;
                    filt_next   = sum_upd[SUM_W-1:FILTER_SHIFT];
                    idx_next    = '0;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (idx_reg == '0) begin
                    // cold clamp at or above the first entry
                    if (filt_reg >= tab_val) begin
                        temp_next  = '0;
                        state_next = ST_FINISH;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end else if (filt_reg > tab_val) begin
                    // segment found: set up the interpolation divide
                    div_next   = tab_prev - tab_val;
                    rem_next   = num[NUM_W-1:QUOT_W];
                    quot_next  = num[QUOT_W-1:0];
                    cnt_next   = CNT_W'(QUOT_W - 1);
                    temp_next  = TEMP_W'(idx_reg - IDX_W'(1)) * TEMP_W'(STEP_DECI);
                    state_next = ST_DIVIDE;
                end else if (idx_reg == IDX_LAST) begin
                    // hot clamp at or below the last entry
                    temp_next  = TEMP_W'(TEMP_MAX);
                    state_next = ST_FINISH;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DIVIDE: begin
                rem_next  = trial_ge ? trial_diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
                quot_next = quot_upd;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    temp_next  = temp_reg + TEMP_W'(quot_upd);
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_temp_next  = temp_reg;
                    m_filt_next  = filt_reg;
                    m_hot_next   = (temp_reg >= limit_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            seeded_reg  <= 1'b0;
            limit_reg   <= LIMIT_W'(LIMIT_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            seeded_reg  <= seeded_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        filt_reg   <= filt_next;
        idx_reg    <= idx_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        cnt_reg    <= cnt_next;
        temp_reg   <= temp_next;
        m_temp_reg <= m_temp_next;
        m_filt_reg <= m_filt_next;
        m_hot_reg  <= m_hot_next;
    end

endmodule

`default_nettype wire
